FILE: hdl/qvr_pkg.sv
// qvr_pkg: payload types and widths shared by the quaternion vector rotate unit
package qvr_pkg;

	localparam int QUAT_W = 16;
	localparam int VEC_W  = 32;
	localparam int HALF_W = VEC_W / 2;
	localparam int PROD_W = 2 * QUAT_W;
	localparam int MAT_W  = PROD_W + 2;
	localparam int PH_W   = MAT_W + HALF_W;
	localparam int PL_W   = MAT_W + HALF_W + 1;
	localparam int SH_W   = PH_W + 2;
	localparam int SL_W   = PL_W + 2;
	localparam int TOT_W  = SL_W + 1;
	localparam int RND_SH = 12;
	localparam int RES_W  = TOT_W - RND_SH;
	localparam int LOW_SH = 16;
	localparam int HALF_LSB_POS = 27;

	typedef struct packed {
		logic signed [QUAT_W-1:0] quat_w;
		logic signed [QUAT_W-1:0] quat_x;
		logic signed [QUAT_W-1:0] quat_y;
		logic signed [QUAT_W-1:0] quat_z;
		logic signed [VEC_W-1:0]  vec_x;
		logic signed [VEC_W-1:0]  vec_y;
		logic signed [VEC_W-1:0]  vec_z;
		logic signed [VEC_W-1:0]  vec_w;
	} qvr_in_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] out_x;
		logic signed [VEC_W-1:0] out_y;
		logic signed [VEC_W-1:0] out_z;
		logic signed [VEC_W-1:0] out_w;
		logic                    saturated;
	} qvr_out_t;

endpackage

FILE: hdl/quaternion_vector_rotate_unit.sv
// quaternion_vector_rotate_unit: five-stage pipelined rotation of a vector by a quaternion
//
// Rotates (vec_x, vec_y, vec_z) by the quaternion (quat_w, quat_x, quat_y, quat_z) through the
// rotation matrix of the quaternion, rounded once to Q16.16 and saturated; vec_w is copied to
// out_w. The quaternion is not normalised, so its squared norm scales the result. A transfer
// is taken on every clock edge with start high; busy is always low. Each result appears on
// result with done high for exactly one cycle, one result per cycle at full rate. The
// five-stage multiply and sum pipeline lies between a transfer and its result. The receiver
// cannot hold results off, so it must take every result in the cycle it is shown.
module quaternion_vector_rotate_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  qvr_pkg::qvr_in_t  item,
	output logic            done,
	output qvr_pkg::qvr_out_t result
);
	import qvr_pkg::*;

	localparam logic signed [RES_W-1:0] R_MAX = RES_W'(64'sd2147483647);
	localparam logic signed [RES_W-1:0] R_MIN = -RES_W'(64'sd2147483648);
	localparam logic signed [SL_W-1:0]  HALF_LSB = SL_W'(1) << HALF_LSB_POS;

	// stage 1: quaternion products and vector halves
	logic                       v_s1;
	logic signed [PROD_W-1:0]   ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1;
	logic signed [PROD_W-1:0]   wx_s1, wy_s1, wz_s1;
	logic signed [HALF_W-1:0]   vh_s1 [3];
	logic        [HALF_W-1:0]   vl_s1 [3];
	logic signed [VEC_W-1:0]    w_s1;

	// stage 2: rotation matrix
	logic                       v_s2;
	logic signed [MAT_W-1:0]    m_d   [3][3];
	logic signed [MAT_W-1:0]    m_s2  [3][3];
	logic signed [HALF_W-1:0]   vh_s2 [3];
	logic        [HALF_W-1:0]   vl_s2 [3];
	logic signed [VEC_W-1:0]    w_s2;

	// stage 3: partial products
	logic                       v_s3;
	logic signed [PH_W-1:0]     ph_s3 [3][3];
	logic signed [PL_W-1:0]     pl_s3 [3][3];
	logic signed [VEC_W-1:0]    w_s3;

	// stage 4: row sums
	logic                       v_s4;
	logic signed [SH_W-1:0]     sh_s4 [3];
	logic signed [SL_W-1:0]     sl_s4 [3];
	logic signed [VEC_W-1:0]    w_s4;

	// stage 5: round and saturate
	logic signed [TOT_W-1:0]    tot   [3];
	logic signed [RES_W-1:0]    rnd   [3];
	logic signed [VEC_W-1:0]    sat_v [3];
	logic        [2:0]          clip;
	logic                       v_s5;
	qvr_out_t                   res_s5;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ww_s1 <= item.quat_w * item.quat_w;
		xx_s1 <= item.quat_x * item.quat_x;
		yy_s1 <= item.quat_y * item.quat_y;
		zz_s1 <= item.quat_z * item.quat_z;
		xy_s1 <= item.quat_x * item.quat_y;
		xz_s1 <= item.quat_x * item.quat_z;
		yz_s1 <= item.quat_y * item.quat_z;
		wx_s1 <= item.quat_w * item.quat_x;
		wy_s1 <= item.quat_w * item.quat_y;
		wz_s1 <= item.quat_w * item.quat_z;
		vh_s1[0] <= item.vec_x[VEC_W-1:HALF_W];
		vh_s1[1] <= item.vec_y[VEC_W-1:HALF_W];
		vh_s1[2] <= item.vec_z[VEC_W-1:HALF_W];
		vl_s1[0] <= item.vec_x[HALF_W-1:0];
		vl_s1[1] <= item.vec_y[HALF_W-1:0];
		vl_s1[2] <= item.vec_z[HALF_W-1:0];
		w_s1     <= item.vec_w;
	end

	always_comb begin
		m_d[0][0] = MAT_W'(ww_s1) + MAT_W'(xx_s1) - MAT_W'(yy_s1) - MAT_W'(zz_s1);
		m_d[1][1] = MAT_W'(ww_s1) - MAT_W'(xx_s1) + MAT_W'(yy_s1) - MAT_W'(zz_s1);
		m_d[2][2] = MAT_W'(ww_s1) - MAT_W'(xx_s1) - MAT_W'(yy_s1) + MAT_W'(zz_s1);
		m_d[0][1] = (MAT_W'(xy_s1) - MAT_W'(wz_s1)) <<< 1;
		m_d[0][2] = (MAT_W'(xz_s1) + MAT_W'(wy_s1)) <<< 1;
		m_d[1][0] = (MAT_W'(xy_s1) + MAT_W'(wz_s1)) <<< 1;
		m_d[1][2] = (MAT_W'(yz_s1) - MAT_W'(wx_s1)) <<< 1;
		m_d[2][0] = (MAT_W'(xz_s1) - MAT_W'(wy_s1)) <<< 1;
		m_d[2][1] = (MAT_W'(yz_s1) + MAT_W'(wx_s1)) <<< 1;
	end

	always_ff @(posedge clk) begin
		m_s2  <= m_d;
		vh_s2 <= vh_s1;
		vl_s2 <= vl_s1;
		w_s2  <= w_s1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				ph_s3[i][j] <= PH_W'(m_s2[i][j]) * PH_W'(vh_s2[j]);
				pl_s3[i][j] <= PL_W'(m_s2[i][j]) * PL_W'($signed({1'b0, vl_s2[j]}));
			end
		end
		w_s3 <= w_s2;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sh_s4[i] <= SH_W'(ph_s3[i][0]) + SH_W'(ph_s3[i][1]) + SH_W'(ph_s3[i][2]);
			sl_s4[i] <= SL_W'(pl_s3[i][0]) + SL_W'(pl_s3[i][1]) + SL_W'(pl_s3[i][2])
				+ HALF_LSB;
		end
		w_s4 <= w_s3;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tot[i] = TOT_W'(sh_s4[i]) + TOT_W'(sl_s4[i] >>> LOW_SH);
			rnd[i] = RES_W'(tot[i] >>> RND_SH);
			if (rnd[i] > R_MAX) begin
				sat_v[i] = R_MAX[VEC_W-1:0];
				clip[i]  = 1'b1;
			end else if (rnd[i] < R_MIN) begin
				sat_v[i] = R_MIN[VEC_W-1:0];
				clip[i]  = 1'b1;
			end else begin
				sat_v[i] = rnd[i][VEC_W-1:0];
				clip[i]  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_s5.out_x     <= sat_v[0];
		res_s5.out_y     <= sat_v[1];
		res_s5.out_z     <= sat_v[2];
		res_s5.out_w     <= w_s4;
		res_s5.saturated <= |clip;
	end

	assign done   = v_s5;
	assign result = res_s5;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##5 done)
		else $error("accepted item gave no result after five cycles");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("result without a matching transfer");

	a_pass_w: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.out_w == $past(item.vec_w, 5)))
		else $error("fourth component not carried with its item");

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturated) |->
			(result.out_x == R_MAX[VEC_W-1:0] || result.out_x == R_MIN[VEC_W-1:0] ||
			 result.out_y == R_MAX[VEC_W-1:0] || result.out_y == R_MIN[VEC_W-1:0] ||
			 result.out_z == R_MAX[VEC_W-1:0] || result.out_z == R_MIN[VEC_W-1:0]))
		else $error("saturated flag without a clipped component");

endmodule

FILE: verif/tb_quaternion_vector_rotate_unit.sv
// tb_quaternion_vector_rotate_unit: self-checking bench for the quaternion vector rotate unit
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate_unit;
	import qvr_pkg::*;

	localparam int ITEM_COUNT  = 1700;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 10;
	localparam longint OUT_HI = 64'sd2147483647;
	localparam longint OUT_LO = -64'sd2147483648;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	qvr_in_t  item;
	logic     done;
	qvr_out_t result;

	qvr_in_t  feed_queue [$];
	int       gap_queue [$];
	qvr_out_t rotations_due [$];
	qvr_out_t want;
	logic     took_item;
	int       wait_left;
	int       stall_cycles;
	int       mismatches;

	quaternion_vector_rotate_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// rotation matrix of q applied to v, one rounding to Q16.16 then clipping
	function automatic qvr_out_t rotate_vector(qvr_in_t it);
		longint qw, qx, qy, qz;
		longint hi [3];
		longint lo [3];
		longint mat [3][3];
		longint acc_hi, acc_lo, total, rounded;
		logic [VEC_W-1:0] comp [3];
		logic [VEC_W-1:0] rot [3];
		logic [HALF_W-1:0] lo_bits;
		logic signed [HALF_W-1:0] hi_bits;
		qvr_out_t r;
		qw = it.quat_w;
		qx = it.quat_x;
		qy = it.quat_y;
		qz = it.quat_z;
		comp[0] = it.vec_x;
		comp[1] = it.vec_y;
		comp[2] = it.vec_z;
		for (int i = 0; i < 3; i++) begin
			lo_bits = comp[i][HALF_W-1:0];
			hi_bits = comp[i][VEC_W-1:HALF_W];
			lo[i] = lo_bits;
			hi[i] = hi_bits;
		end
		mat[0][0] = qw*qw + qx*qx - qy*qy - qz*qz;
		mat[0][1] = 2 * (qx*qy - qw*qz);
		mat[0][2] = 2 * (qx*qz + qw*qy);
		mat[1][0] = 2 * (qx*qy + qw*qz);
		mat[1][1] = qw*qw - qx*qx + qy*qy - qz*qz;
		mat[1][2] = 2 * (qy*qz - qw*qx);
		mat[2][0] = 2 * (qx*qz - qw*qy);
		mat[2][1] = 2 * (qy*qz + qw*qx);
		mat[2][2] = qw*qw - qx*qx - qy*qy + qz*qz;
		r.saturated = 1'b0;
		for (int i = 0; i < 3; i++) begin
			acc_hi = mat[i][0]*hi[0] + mat[i][1]*hi[1] + mat[i][2]*hi[2];
			acc_lo = mat[i][0]*lo[0] + mat[i][1]*lo[1] + mat[i][2]*lo[2]
				+ (longint'(1) <<< HALF_LSB_POS);
			total = acc_hi + (acc_lo >>> LOW_SH);
			rounded = total >>> RND_SH;
			if (rounded > OUT_HI) begin
				rounded = OUT_HI;
				r.saturated = 1'b1;
			end else if (rounded < OUT_LO) begin
				rounded = OUT_LO;
				r.saturated = 1'b1;
			end
			rot[i] = rounded[VEC_W-1:0];
		end
		r.out_x = rot[0];
		r.out_y = rot[1];
		r.out_z = rot[2];
		r.out_w = it.vec_w;
		return r;
	endfunction

	function automatic qvr_in_t make_item(int w, int x, int y, int z,
			int vx, int vy, int vz, int vw);
		qvr_in_t r;
		r.quat_w = w[QUAT_W-1:0];
		r.quat_x = x[QUAT_W-1:0];
		r.quat_y = y[QUAT_W-1:0];
		r.quat_z = z[QUAT_W-1:0];
		r.vec_x  = vx;
		r.vec_y  = vy;
		r.vec_z  = vz;
		r.vec_w  = vw;
		return r;
	endfunction

	// extremes, zero, minus one, one or random, at the given width
	function automatic logic [31:0] corner_value(int bits);
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = 32'h1 << (bits - 1);
			1: v = (32'h1 << (bits - 1)) - 1;
			2: v = '0;
			3: v = '1;
			4: v = 32'h1;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic int near_unit();
		int v;
		v = $urandom_range(0, 23170);
		return v - 11585;
	endfunction

	function automatic int modest_vec();
		int v;
		v = $urandom_range(0, 32'h00FF_FFFF);
		return v - 32'h0080_0000;
	endfunction

	task automatic queue_item(qvr_in_t it, int gap);
		feed_queue.push_back(it);
		gap_queue.push_back(gap);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && (!start || took_item)) begin
			if (wait_left > 0) begin
				start <= 1'b0;
				wait_left--;
			end else if (feed_queue.size() != 0) begin
				item <= feed_queue.pop_front();
				wait_left = gap_queue.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// transfer capture, result check and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			took_item <= 1'b0;
			stall_cycles <= 0;
		end else begin
			took_item <= start && !busy;
			if (start && !busy)
				rotations_due.push_back(rotate_vector(item));
			if (done) begin
				if (rotations_due.size() == 0) begin
					$error("result with no transfer outstanding");
					mismatches++;
				end else begin
					want = rotations_due.pop_front();
					if (result.out_x !== want.out_x) begin
						$error("out_x: expected %0d, got %0d", want.out_x, result.out_x);
						mismatches++;
					end
					if (result.out_y !== want.out_y) begin
						$error("out_y: expected %0d, got %0d", want.out_y, result.out_y);
						mismatches++;
					end
					if (result.out_z !== want.out_z) begin
						$error("out_z: expected %0d, got %0d", want.out_z, result.out_z);
						mismatches++;
					end
					if (result.out_w !== want.out_w) begin
						$error("out_w: expected %0d, got %0d", want.out_w, result.out_w);
						mismatches++;
					end
					if (result.saturated !== want.saturated) begin
						$error("saturated: expected %0d, got %0d",
							want.saturated, result.saturated);
						mismatches++;
					end
				end
			end
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		qvr_in_t it;
		int      gap;
		bit      burst;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		wait_left = 0;
		mismatches = 0;

		// directed
		queue_item(make_item(16384, 0, 0, 0, 65536, 131072, 196608, 0), 0);
		queue_item(make_item(-16384, 0, 0, 0, -65536, 7, 32'h0001_8000, 5), 1);
		queue_item(make_item(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, -1, -1), 0);
		queue_item(make_item(11585, 0, 0, 11585, 65536, 0, 0, 1), 2);
		queue_item(make_item(11585, 0, 11585, 0, 0, 0, 65536, 2), 0);
		queue_item(make_item(0, 16384, 0, 0, 65536, 65536, 65536, 3), 0);
		queue_item(make_item(0, -32768, 0, 0, 65536, -65536, 65536, 4), 3);
		queue_item(make_item(-32768, -32768, -32768, -32768, 100, -200, 300, 0), 0);
		queue_item(make_item(32767, 32767, 32767, 32767,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0);
		queue_item(make_item(-32768, 0, 0, 0,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000), 1);
		queue_item(make_item(-32768, 0, 0, 0,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0), 0);
		queue_item(make_item(16384, 0, 0, 0,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF), 0);
		queue_item(make_item(16384, 0, 0, 0,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000), 5);
		// half-lsb ties round upwards
		queue_item(make_item(1, 0, 0, 0, 134217728, -134217728, 402653184, 0), 0);
		queue_item(make_item(1, 0, 0, 0, 134217727, -134217729, 402653183, 0), 0);
		queue_item(make_item(0, 0, 0, 1, 134217728, -134217728, 0, 0), 0);
		queue_item(make_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA), 0);
		queue_item(make_item(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555), 4);
		queue_item(make_item(12345, -23456, 31000, -7, 0, 0, 0, -12345), 0);
		queue_item(make_item(32767, -32768, 0, 0, -1, 1, -1, 0), 0);

		// random
		for (int i = 0; i < ITEM_COUNT; i++) begin
			burst = ((i / 100) % 3) == 0;
			case ($urandom_range(0, 3))
				0: it = qvr_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
				1: it = make_item(near_unit(), near_unit(), near_unit(), near_unit(),
					modest_vec(), modest_vec(), modest_vec(), $urandom);
				2: it = make_item($urandom, $urandom, $urandom, $urandom,
					modest_vec(), modest_vec(), modest_vec(), $urandom);
				default: it = make_item(corner_value(QUAT_W), corner_value(QUAT_W),
					corner_value(QUAT_W), corner_value(QUAT_W), corner_value(VEC_W),
					corner_value(VEC_W), corner_value(VEC_W), corner_value(VEC_W));
			endcase
			gap = burst ? 0 : $urandom_range(0, 5);
			queue_item(it, gap);
		end

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		while (feed_queue.size() != 0 || start || rotations_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: files.f
hdl/qvr_pkg.sv
hdl/quaternion_vector_rotate_unit.sv
verif/tb_quaternion_vector_rotate_unit.sv
